### rtl/core/lphm_pkg.sv
// Package for the linear probe hash map core.
// Holds the table sizes, action and status codes, the sequencer states and the
// write-port struct. It depends on nothing else.
package lphm_pkg;

    localparam int SLOT_W      = 10;
    localparam int TABLE_SLOTS = 1 << SLOT_W;
    localparam int CNT_W       = 11;
    localparam int KEY_W       = 64;
    localparam int VAL_W       = 64;
    localparam int ACT_W       = 3;
    localparam int STAT_W      = 2;
    localparam int IN_DATA_W   = 128;
    localparam int OUT_DATA_W  = 80;

    localparam logic [63:0] FNV_OFFSET = 64'hCBF29CE484222325;
    localparam logic [63:0] FNV_PRIME  = 64'h00000100000001B3;

    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [CNT_W-1:0]  t_count;

    typedef enum logic [ACT_W-1:0] {
        ACT_SET    = 3'd0,
        ACT_GET    = 3'd1,
        ACT_HAS    = 3'd2,
        ACT_REMOVE = 3'd3,
        ACT_CLEAR  = 3'd4
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 2'd0,
        ST_ABSENT = 2'd1,
        ST_FULL   = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_HASH,
        S_RD,
        S_CK,
        S_DONE
    } t_state;

    // mark bit 1: used, bit 0: tombstone
    typedef struct packed {
        t_slot             addr;
        logic              key_we;
        logic              val_we;
        logic              mark_we;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
        logic [1:0]        mark;
    } t_wr;

endpackage

### rtl/core/linear_probe_hash_map_core.sv
// Open-addressing key/value table of 1024 slots with linear probing. An item
// is accepted, then the byte-serial hash unit is started and run, then each
// probed slot takes a registered memory read, then a check; last the result is
// handed over. A full probe covers all 1024 slots.
// After reset and on every clear action, a sweep writes all 1024 mark entries,
// one a cycle, and no beat is taken during the sweep.
module linear_probe_hash_map_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [lphm_pkg::IN_DATA_W-1:0]      i_s_tdata,   // key[63:0], value[127:64]
    input  logic [lphm_pkg::ACT_W-1:0]          i_s_tuser,   // action[2:0]
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [lphm_pkg::OUT_DATA_W-1:0]     o_m_tdata,   // result_value[63:0], entry_count[74:64], zero[79:75]
    output logic [lphm_pkg::STAT_W-1:0]         o_m_tuser    // status[1:0]
);
    import lphm_pkg::*;

    t_state             r_state, n_state;
    t_slot              r_slot, n_slot;
    t_slot              r_tomb_at, n_tomb_at;
    logic               r_have_tomb, n_have_tomb;
    logic [CNT_W-1:0]   r_n, n_n;
    t_count             r_count, n_count;
    logic [ACT_W-1:0]   r_act, n_act;
    logic [KEY_W-1:0]   r_key, n_key;
    logic [VAL_W-1:0]   r_val, n_val;
    logic [VAL_W-1:0]   r_res, n_res;
    t_status            r_stat, n_stat;
    logic               r_ovalid, n_ovalid;
    logic [VAL_W-1:0]   r_ores, n_ores;
    t_status            r_ostat, n_ostat;
    t_count             r_ocount, n_ocount;

    logic               w_hstart, w_hdone;
    t_slot              w_hslot;
    t_wr                w_wr;
    logic [KEY_W-1:0]   w_rkey;
    logic [VAL_W-1:0]   w_rval;
    logic [1:0]         w_rmark;
    logic               w_last;

    lphm_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_hstart),
        .i_key   (r_key),
        .o_done  (w_hdone),
        .o_slot  (w_hslot)
    );

    lphm_store u_store (
        .i_clk     (i_clk),
        .i_wr      (w_wr),
        .i_rd_addr (r_slot),
        .o_key     (w_rkey),
        .o_value   (w_rval),
        .o_mark    (w_rmark)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign w_last     = (r_n == CNT_W'(TABLE_SLOTS - 1));

    always_comb begin
        n_state     = r_state;
        n_slot      = r_slot;
        n_tomb_at   = r_tomb_at;
        n_have_tomb = r_have_tomb;
        n_n         = r_n;
        n_count     = r_count;
        n_act       = r_act;
        n_key       = r_key;
        n_val       = r_val;
        n_res       = r_res;
        n_stat      = r_stat;
        n_ovalid    = r_ovalid;
        n_ores      = r_ores;
        n_ostat     = r_ostat;
        n_ocount    = r_ocount;
        w_hstart    = 1'b0;
        w_wr        = '0;
        w_wr.addr   = r_slot;
        w_wr.key    = r_key;
        w_wr.value  = r_val;

        if (r_ovalid && i_m_tready) n_ovalid = 1'b0;

        unique case (r_state)
            S_CLR: begin
                w_wr.mark_we = 1'b1;
                w_wr.mark    = 2'b00;
                n_slot       = r_slot + 1'b1;
                if (r_slot == t_slot'(TABLE_SLOTS - 1)) begin
                    n_state = (r_act == ACT_CLEAR) ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_act       = i_s_tuser;
                    n_key       = i_s_tdata[KEY_W-1:0];
                    n_val       = i_s_tdata[KEY_W+VAL_W-1:KEY_W];
                    n_res       = '0;
                    n_stat      = ST_OK;
                    n_have_tomb = 1'b0;
                    n_n         = '0;
                    n_slot      = '0;
                    if (i_s_tuser == ACT_CLEAR) begin
                        n_count = '0;
                        n_state = S_CLR;
                    end else if (i_s_tuser > ACT_CLEAR) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_HASH;
                    end
                end
            end
            S_HASH: begin
                if (r_n == '0) begin
                    w_hstart = 1'b1;
                    n_n      = CNT_W'(1);
                end else if (w_hdone) begin
                    n_slot  = w_hslot;
                    n_n     = '0;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_CK;
            end
            S_CK: begin
                priority if (!w_rmark[1]) begin
                    n_state = S_DONE;
                    if (r_act == ACT_SET) begin
                        w_wr.addr    = r_have_tomb ? r_tomb_at : r_slot;
                        w_wr.key_we  = 1'b1;
                        w_wr.val_we  = 1'b1;
                        w_wr.mark_we = 1'b1;
                        w_wr.mark    = 2'b10;
                        n_count      = r_count + 1'b1;
                    end else begin
                        n_stat = ST_ABSENT;
                    end
                end else if (!w_rmark[0] && w_rkey == r_key) begin
                    n_state = S_DONE;
                    unique case (r_act)
                        ACT_SET: w_wr.val_we = 1'b1;
                        ACT_GET: n_res = w_rval;
                        ACT_REMOVE: begin
                            w_wr.mark_we = 1'b1;
                            w_wr.mark    = 2'b11;
                            n_count      = r_count - 1'b1;
                        end
                        default: ;
                    endcase
                end else if (w_last) begin
                    n_state = S_DONE;
                    if (r_act == ACT_SET) begin
                        if (r_have_tomb || w_rmark[0]) begin
                            w_wr.addr    = r_have_tomb ? r_tomb_at : r_slot;
                            w_wr.key_we  = 1'b1;
                            w_wr.val_we  = 1'b1;
                            w_wr.mark_we = 1'b1;
                            w_wr.mark    = 2'b10;
                            n_count      = r_count + 1'b1;
                        end else begin
                            n_stat = ST_FULL;
                        end
                    end else begin
                        n_stat = ST_ABSENT;
                    end
                end else begin
                    if (w_rmark[0] && !r_have_tomb) begin
                        n_have_tomb = 1'b1;
                        n_tomb_at   = r_slot;
                    end
                    n_slot  = r_slot + 1'b1;
                    n_n     = r_n + 1'b1;
                    n_state = S_RD;
                end
            end
            S_DONE: begin
                if (!r_ovalid || i_m_tready) begin
                    n_ovalid = 1'b1;
                    n_ores   = r_res;
                    n_ostat  = r_stat;
                    n_ocount = r_count;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_slot   <= '0;
            r_n      <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
            r_res    <= '0;
            r_stat   <= ST_OK;
            r_act    <= ACT_SET;
        end else begin
            r_state  <= n_state;
            r_slot   <= n_slot;
            r_n      <= n_n;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
            r_res    <= n_res;
            r_stat   <= n_stat;
            r_act    <= n_act;
        end
        r_tomb_at   <= n_tomb_at;
        r_have_tomb <= n_have_tomb;
        r_key       <= n_key;
        r_val       <= n_val;
        r_ores      <= n_ores;
        r_ostat     <= n_ostat;
        r_ocount    <= n_ocount;
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {(OUT_DATA_W - VAL_W - CNT_W)'(0), r_ocount, r_ores};
    assign o_m_tuser  = r_ostat;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_SLOTS))
        else $error("live count beyond table size");

    a_full_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == ST_FULL) |-> (r_ocount == CNT_W'(TABLE_SLOTS)))
        else $error("set dropped while table not full");

    a_key_write_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr.key_we |-> (w_wr.mark_we && w_wr.val_we))
        else $error("key written without value and mark");

    a_hash_done_in_hash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_hdone |-> (r_state == S_HASH))
        else $error("hash finished outside hash phase");

endmodule

### rtl/core/lphm_hash.sv
// Iterative FNV-1a home slot unit: one key byte per cycle, low byte first.
// Only the low slot bits of the hash are kept, as they depend only on low bits.
// Depends on lphm_pkg.
module lphm_hash (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [lphm_pkg::KEY_W-1:0]  i_key,
    output logic                        o_done,
    output lphm_pkg::t_slot             o_slot
);
    import lphm_pkg::*;

    logic             r_busy, n_busy;
    logic [2:0]       r_cnt, n_cnt;
    logic [KEY_W-1:0] r_key, n_key;
    t_slot            r_h, n_h;
    t_slot            w_mix;
    logic [2*SLOT_W-1:0] w_prod;

    assign w_mix  = r_h ^ SLOT_W'(r_key[7:0]);
    assign w_prod = w_mix * FNV_PRIME[SLOT_W-1:0];

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_key  = r_key;
        n_h    = r_h;
        o_done = 1'b0;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = 3'd0;
            n_key  = i_key;
            n_h    = FNV_OFFSET[SLOT_W-1:0];
        end else if (r_busy) begin
            n_h   = w_prod[SLOT_W-1:0];
            n_key = r_key >> 8;
            n_cnt = r_cnt + 3'd1;
            if (r_cnt == 3'd7) begin
                n_busy = 1'b0;
                o_done = 1'b1;
            end
        end
    end

    assign o_slot = w_prod[SLOT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 3'd0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_key <= n_key;
        r_h   <= n_h;
    end

endmodule

### rtl/core/lphm_store.sv
// Slot storage: key, value and mark memories with one write and one read port.
// Read data is registered. Depends on lphm_pkg.
module lphm_store (
    input  logic                        i_clk,
    input  lphm_pkg::t_wr               i_wr,
    input  lphm_pkg::t_slot             i_rd_addr,
    output logic [lphm_pkg::KEY_W-1:0]  o_key,
    output logic [lphm_pkg::VAL_W-1:0]  o_value,
    output logic [1:0]                  o_mark
);
    import lphm_pkg::*;

    logic [KEY_W-1:0] r_keys  [TABLE_SLOTS];
    logic [VAL_W-1:0] r_vals  [TABLE_SLOTS];
    logic [1:0]       r_marks [TABLE_SLOTS];

    always_ff @(posedge i_clk) begin
        if (i_wr.key_we)  r_keys[i_wr.addr]  <= i_wr.key;
        if (i_wr.val_we)  r_vals[i_wr.addr]  <= i_wr.value;
        if (i_wr.mark_we) r_marks[i_wr.addr] <= i_wr.mark;
        o_key   <= r_keys[i_rd_addr];
        o_value <= r_vals[i_rd_addr];
        o_mark  <= r_marks[i_rd_addr];
    end

endmodule

### bench/tb.sv
// Testbench for linear_probe_hash_map_core: a directed table, then random beats,
// checked beat by beat against fixed replies for typed rows, else an in-bench model.
// Depends on lphm_pkg and the core RTL.
`timescale 1ns / 1ps

module tb;
    import lphm_pkg::*;

    localparam logic [ACT_W-1:0] ACT_SPARE_5 = 3'd5;
    localparam logic [ACT_W-1:0] ACT_SPARE_6 = 3'd6;
    localparam logic [ACT_W-1:0] ACT_SPARE_7 = 3'd7;
    localparam int IDLE_LIMIT = 60000;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_BEATS = 628;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [VAL_W-1:0]  value;
        logic [STAT_W-1:0] status;
        t_count            count;
    } t_reply;

    typedef struct {
        logic [ACT_W-1:0] act;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        bit               typed;
        t_reply           reply;
    } t_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata;   // key[63:0], value[127:64]
    logic [ACT_W-1:0]      i_s_tuser;   // action[2:0]
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [OUT_DATA_W-1:0] o_m_tdata;   // result_value[63:0], entry_count[74:64]
    logic [STAT_W-1:0]     o_m_tuser;   // status[1:0]

    linear_probe_hash_map_core i_dut (.*);

    // model state
    logic [KEY_W-1:0] slot_key   [TABLE_SLOTS];
    logic [VAL_W-1:0] slot_value [TABLE_SLOTS];
    bit               slot_used  [TABLE_SLOTS];
    bit               slot_tomb  [TABLE_SLOTS];
    t_count           live_entries;

    t_reply pending_replies[$];
    int     mismatches;
    int     idle_cycles;
    int     replies_seen;
    logic [KEY_W-1:0] key_pool[$];
    t_row   directed[$];

    initial begin
        i_clk = 1'b0;
        forever begin
            #5 i_clk = 1'b1;
            #5 i_clk = 1'b0;
        end
    end

    function automatic t_slot fnv_slot(logic [KEY_W-1:0] k);
        logic [63:0] h;
        h = FNV_OFFSET;
        for (int b = 0; b < 8; b++) begin
            h = h ^ {56'd0, k[8*b +: 8]};
            h = h * FNV_PRIME;
        end
        return h[SLOT_W-1:0];
    endfunction

    function automatic int find_live(logic [KEY_W-1:0] k);
        t_slot s;
        s = fnv_slot(k);
        for (int n = 0; n < TABLE_SLOTS; n++) begin
            if (!slot_used[s]) return -1;
            if (!slot_tomb[s] && slot_key[s] == k) return int'(s);
            s = s + 1'b1;
        end
        return -1;
    endfunction

    function automatic void occupy(t_slot s, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
        slot_key[s] = k;
        slot_value[s] = v;
        slot_used[s] = 1'b1;
        slot_tomb[s] = 1'b0;
        live_entries = live_entries + 1'b1;
    endfunction

    function automatic t_reply apply_action(logic [ACT_W-1:0] act, logic [KEY_W-1:0] k,
                                            logic [VAL_W-1:0] v);
        t_reply r;
        t_slot s;
        t_slot tomb_at;
        bit have_tomb;
        bit done;
        int at;
        r = '0;
        r.status = ST_OK;
        case (act)
            ACT_SET: begin
                s = fnv_slot(k);
                have_tomb = 1'b0;
                done = 1'b0;
                tomb_at = '0;
                for (int n = 0; n < TABLE_SLOTS && !done; n++) begin
                    if (!slot_used[s]) begin
                        occupy(have_tomb ? tomb_at : s, k, v);
                        done = 1'b1;
                    end else if (slot_tomb[s]) begin
                        if (!have_tomb) begin
                            have_tomb = 1'b1;
                            tomb_at = s;
                        end
                    end else if (slot_key[s] == k) begin
                        slot_value[s] = v;
                        done = 1'b1;
                    end
                    s = s + 1'b1;
                end
                if (!done) begin
                    if (have_tomb) occupy(tomb_at, k, v);
                    else r.status = ST_FULL;
                end
            end
            ACT_GET: begin
                at = find_live(k);
                if (at < 0) r.status = ST_ABSENT;
                else r.value = slot_value[at];
            end
            ACT_HAS: begin
                if (find_live(k) < 0) r.status = ST_ABSENT;
            end
            ACT_REMOVE: begin
                at = find_live(k);
                if (at < 0) begin
                    r.status = ST_ABSENT;
                end else begin
                    slot_tomb[at] = 1'b1;
                    live_entries = live_entries - 1'b1;
                end
            end
            ACT_CLEAR: begin
                for (int i = 0; i < TABLE_SLOTS; i++) begin
                    slot_used[i] = 1'b0;
                    slot_tomb[i] = 1'b0;
                end
                live_entries = '0;
            end
            default: ;
        endcase
        r.count = live_entries;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // hold the beat until accepted, then record what it should return
    task automatic send_beat(logic [ACT_W-1:0] act, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v,
                             bit typed, t_reply typed_reply, bit no_gap);
        int gap;
        t_reply r;
        gap = no_gap ? 0 : pick_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {v, k};
        i_s_tuser <= act;
        do @(posedge i_clk); while (!o_s_tready);
        r = apply_action(act, k, v);
        pending_replies.push_back(typed ? typed_reply : r);
    endtask

    function automatic void add_row(logic [ACT_W-1:0] act, logic [KEY_W-1:0] k,
                                    logic [VAL_W-1:0] v, bit typed,
                                    logic [VAL_W-1:0] ev, logic [STAT_W-1:0] es, int ec);
        t_row row;
        row.act = act;
        row.key = k;
        row.value = v;
        row.typed = typed;
        row.reply.value = ev;
        row.reply.status = es;
        row.reply.count = t_count'(ec);
        directed.push_back(row);
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return key_pool[$urandom_range(0, key_pool.size() - 1)];
        return {$urandom, $urandom};
    endfunction

    function automatic logic [ACT_W-1:0] pick_action();
        int r;
        r = $urandom_range(0, 99);
        if (r < 38) return ACT_SET;
        if (r < 62) return ACT_GET;
        if (r < 76) return ACT_HAS;
        if (r < 94) return ACT_REMOVE;
        if (r < 97) return ACT_CLEAR;
        return ACT_W'($urandom_range(ACT_SPARE_5, ACT_SPARE_7));
    endfunction

    // sender
    initial begin
        t_slot shared;
        logic [KEY_W-1:0] cand;
        logic [KEY_W-1:0] max_key;
        logic [KEY_W-1:0] min_key;
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tuser = '0;
        mismatches = 0;
        live_entries = '0;
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            slot_used[i] = 1'b0;
            slot_tomb[i] = 1'b0;
        end
        max_key = {1'b0, {63{1'b1}}};
        min_key = {1'b1, 63'd0};

        // keys sharing one home slot force probe chains
        shared = fnv_slot(64'd0);
        key_pool.push_back(64'd0);
        cand = 64'd1;
        while (key_pool.size() < 5) begin
            if (fnv_slot(cand) == shared) key_pool.push_back(cand);
            cand = cand + 1;
        end
        for (int i = 0; i < 20; i++) key_pool.push_back({$urandom, $urandom});
        key_pool.push_back(max_key);
        key_pool.push_back(min_key);

        add_row(ACT_GET, max_key, '0, 1, '0, ST_ABSENT, 0);
        add_row(ACT_SET, max_key, min_key, 1, '0, ST_OK, 1);
        add_row(ACT_GET, max_key, '0, 1, min_key, ST_OK, 1);
        add_row(ACT_SET, min_key, max_key, 1, '0, ST_OK, 2);
        add_row(ACT_SET, min_key, '1, 1, '0, ST_OK, 2);
        add_row(ACT_GET, min_key, '0, 1, '1, ST_OK, 2);
        add_row(ACT_HAS, min_key, '1, 1, '0, ST_OK, 2);
        add_row(ACT_HAS, 64'd0, '0, 1, '0, ST_ABSENT, 2);
        add_row(ACT_SET, key_pool[0], 64'd11, 0, '0, '0, 0);
        add_row(ACT_SET, key_pool[1], 64'd22, 0, '0, '0, 0);
        add_row(ACT_SET, key_pool[2], 64'd33, 0, '0, '0, 0);
        add_row(ACT_REMOVE, key_pool[1], '0, 0, '0, '0, 0);
        add_row(ACT_GET, key_pool[2], '0, 0, '0, '0, 0);
        add_row(ACT_SET, key_pool[3], 64'd44, 0, '0, '0, 0);
        add_row(ACT_GET, key_pool[1], '0, 0, '0, '0, 0);
        add_row(ACT_REMOVE, key_pool[1], '0, 0, '0, '0, 0);
        add_row(ACT_SPARE_5, max_key, '1, 0, '0, '0, 0);
        add_row(ACT_SPARE_6, '1, '1, 0, '0, '0, 0);
        add_row(ACT_SPARE_7, '0, '0, 0, '0, '0, 0);
        add_row(ACT_CLEAR, max_key, '1, 1, '0, ST_OK, 0);
        add_row(ACT_GET, min_key, '0, 1, '0, ST_ABSENT, 0);
        add_row(ACT_REMOVE, min_key, '0, 1, '0, ST_ABSENT, 0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[i])
            send_beat(directed[i].act, directed[i].key, directed[i].value,
                      directed[i].typed, directed[i].reply, 1'b0);

        for (int i = 0; i < RANDOM_BEATS; i++)
            send_beat(pick_action(), pick_key(), {$urandom, $urandom}, 0, '0,
                      (i / 40) % 3 == 0);

        i_s_tvalid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end

    // receiver, with one long hold-off to back the core up
    initial begin
        bit held;
        int gap;
        held = 1'b0;
        i_m_tready = 1'b0;
        @(posedge i_clk);
        while (1) begin
            if (!held && replies_seen >= 100) begin
                held = 1'b1;
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            gap = pick_gap();
            if (gap > 0) begin
                i_m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            @(posedge i_clk);
        end
    end

    // checker and watchdog
    always @(posedge i_clk) begin
        t_reply exp_reply;
        if (!i_rst_n) begin
            idle_cycles <= 0;
            replies_seen <= 0;
        end else begin
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
            if (o_m_tvalid && i_m_tready) begin
                replies_seen <= replies_seen + 1;
                if (pending_replies.size() == 0) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10) $display("unexpected beat: %h", o_m_tdata);
                end else begin
                    exp_reply = pending_replies.pop_front();
                    if (o_m_tdata[63:0] !== exp_reply.value || o_m_tuser !== exp_reply.status
                            || o_m_tdata[74:64] !== exp_reply.count) begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10)
                            $display("beat %0d: exp val %h st %0d cnt %0d, got val %h st %0d cnt %0d",
                                     replies_seen, exp_reply.value, exp_reply.status,
                                     exp_reply.count, o_m_tdata[63:0], o_m_tuser,
                                     o_m_tdata[74:64]);
                    end
                end
            end
        end
    end

endmodule

### linear_probe_hash_map_core.f
rtl/core/lphm_pkg.sv
rtl/core/lphm_hash.sv
rtl/core/lphm_store.sv
rtl/core/linear_probe_hash_map_core.sv
bench/tb.sv
